/* design/hjs_pkg.sv */
// Package for the heat Jacobi stencil unit: fixed widths, register indexes,
// controller/datapath command and status types.
// No dependencies.
`default_nettype none

package hjs_pkg;

    localparam int VALUE_W     = 17;
    localparam int COEF_W      = 19;
    localparam int SIZE_W      = 11;
    localparam int CFG_INDEX_W = 3;

    localparam logic [VALUE_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_X = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_Y = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DIAG_X   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DIAG_Y   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_COLS     = 3'd5;

    localparam logic signed [COEF_W-1:0] WEIGHT_RESET = 19'sd16384;
    localparam logic [SIZE_W-1:0]        SIZE_RESET   = 11'd1024;

    typedef struct packed {
        logic accept;
        logic mul1;
        logic sum;
        logic mul2;
        logic commit;
        logic out_load;
    } hjs_cmd_t;

    typedef struct packed {
        logic emit;
    } hjs_status_t;

endpackage

`default_nettype wire

/* design/hjs_cell_if.sv */
// Input channel for the stencil unit: one grid cell per transfer.
// Depends on hjs_pkg.
`default_nettype none

interface hjs_cell_if
    import hjs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] cell_value;
    logic               is_padding;

    modport source (output valid, output cell_value, output is_padding, input ready);
    modport sink   (input valid, input cell_value, input is_padding, output ready);
endinterface

`default_nettype wire

/* design/hjs_result_if.sv */
// Output channel for the stencil unit: one updated cell per transfer.
// Depends on hjs_pkg.
`default_nettype none

interface hjs_result_if
    import hjs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] new_value;
    logic               last_of_grid;

    modport source (output valid, output new_value, output last_of_grid, input ready);
    modport sink   (input valid, input new_value, input last_of_grid, output ready);
endinterface

`default_nettype wire

/* design/hjs_datapath.sv */
// Datapath: config registers, line buffers, window, position counters and the
// multiply/add stages. Driven by hjs_ctrl commands; depends on hjs_pkg.
`default_nettype none

module hjs_datapath
    import hjs_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [COEF_W-1:0]      cfg_wdata,
    input  wire logic [VALUE_W-1:0]     cell_value,
    input  wire logic                   is_padding,
    input  wire hjs_cmd_t               cmd,
    output hjs_status_t                 status,
    output logic [VALUE_W-1:0]          new_value,
    output logic                        last_of_grid
);

    localparam int COLW = $clog2(MAX_COLS);
    localparam int CW   = $clog2(MAX_COLS + 1);
    localparam int RW   = $clog2(MAX_ROWS + 1);
    localparam int ROWW = $clog2(MAX_ROWS + 2);
    localparam int CCW  = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int RCW  = (RW > SIZE_W) ? RW : SIZE_W;
    localparam int PW   = ((ROWW > CW) ? ROWW : CW) + 2;

    logic signed [COEF_W-1:0] weight_x_reg, weight_y_reg, diag_x_reg, diag_y_reg;
    logic [SIZE_W-1:0]        rows_in_use_reg, cols_in_use_reg;

    logic [VALUE_W-1:0] above_mem     [MAX_COLS];
    logic [VALUE_W-1:0] two_above_mem [MAX_COLS];

    logic [VALUE_W-1:0] v_reg, up_rd_reg, mid_rd_reg;
    logic [VALUE_W-1:0] win_center_reg, win_left_reg, win_up_reg, win_down_reg;
    logic [COLW-1:0]    col_cnt_reg, col_cnt_next;
    logic [ROWW-1:0]    row_cnt_reg, row_cnt_next;

    logic signed [36:0] prod_x_reg, prod_y_reg;
    logic signed [20:0] sx_reg, sy_reg;
    logic signed [39:0] tx_reg, ty_reg;
    logic               emit_reg, interior_reg, last_reg;
    logic [VALUE_W-1:0] new_value_reg;
    logic               last_of_grid_reg;

    logic [CCW-1:0]     cols_ext;
    logic [RCW-1:0]     rows_ext;
    logic [CW-1:0]      cols_c;
    logic [RW-1:0]      rows_c;
    logic [PW-1:0]      orow, ocol;
    logic               emit_now, interior_now, last_now;
    logic [VALUE_W-1:0] v_in;
    logic signed [24:0] r_sum;
    logic [VALUE_W-1:0] r_clamped, result;
    logic signed [17:0] center_s;

    // grid size clamp
    always_comb
    begin
        cols_ext = CCW'(cols_in_use_reg);
        rows_ext = RCW'(rows_in_use_reg);
        if (cols_ext < CCW'(3))
            cols_c = CW'(3);
        else if (cols_ext > CCW'(MAX_COLS))
            cols_c = CW'(MAX_COLS);
        else
            cols_c = CW'(cols_ext);
        if (rows_ext < RCW'(3))
            rows_c = RW'(3);
        else if (rows_ext > RCW'(MAX_ROWS))
            rows_c = RW'(MAX_ROWS);
        else
            rows_c = RW'(rows_ext);
    end

    // output position of the cell finished by this transfer
    always_comb
    begin
        emit_now = (PW'(row_cnt_reg) >= PW'(2)) ||
                   ((PW'(row_cnt_reg) == PW'(1)) && (col_cnt_reg != '0));
        if (col_cnt_reg != '0)
        begin
            orow = PW'(row_cnt_reg) - PW'(1);
            ocol = PW'(col_cnt_reg) - PW'(1);
        end
        else
        begin
            orow = PW'(row_cnt_reg) - PW'(2);
            ocol = PW'(cols_c) - PW'(1);
        end
        interior_now = (orow >= PW'(1)) && (orow + PW'(2) <= PW'(rows_c)) &&
                       (ocol >= PW'(1)) && (ocol + PW'(2) <= PW'(cols_c));
        last_now = (orow + PW'(1) >= PW'(rows_c)) && (ocol + PW'(1) >= PW'(cols_c));
    end

    always_comb
    begin
        if (is_padding)
            v_in = '0;
        else if (cell_value > ONE_Q16)
            v_in = ONE_Q16;
        else
            v_in = cell_value;
    end

    always_comb
    begin
        if (PW'(col_cnt_reg) + PW'(1) >= PW'(cols_c))
        begin
            col_cnt_next = '0;
            if (PW'(row_cnt_reg) <= PW'(MAX_ROWS))
                row_cnt_next = row_cnt_reg + ROWW'(1);
            else
                row_cnt_next = row_cnt_reg;
        end
        else
        begin
            col_cnt_next = col_cnt_reg + COLW'(1);
            row_cnt_next = row_cnt_reg;
        end
    end

    assign center_s = $signed({1'b0, win_center_reg});

    always_comb
    begin
        r_sum = $signed({tx_reg[39], tx_reg[39:16]}) + $signed({ty_reg[39], ty_reg[39:16]});
        if (r_sum < 25'sd0)
            r_clamped = '0;
        else if (r_sum > 25'sd65536)
            r_clamped = ONE_Q16;
        else
            r_clamped = r_sum[VALUE_W-1:0];
        result = interior_reg ? r_clamped : win_center_reg;
    end

    // control and config state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_x_reg    <= WEIGHT_RESET;
            weight_y_reg    <= WEIGHT_RESET;
            diag_x_reg      <= '0;
            diag_y_reg      <= '0;
            rows_in_use_reg <= SIZE_RESET;
            cols_in_use_reg <= SIZE_RESET;
            row_cnt_reg     <= '0;
            col_cnt_reg     <= '0;
            win_center_reg  <= '0;
            win_left_reg    <= '0;
            win_up_reg      <= '0;
            win_down_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WEIGHT_X: weight_x_reg    <= $signed(cfg_wdata);
                    REG_WEIGHT_Y: weight_y_reg    <= $signed(cfg_wdata);
                    REG_DIAG_X:   diag_x_reg      <= $signed(cfg_wdata);
                    REG_DIAG_Y:   diag_y_reg      <= $signed(cfg_wdata);
                    REG_ROWS:     rows_in_use_reg <= cfg_wdata[SIZE_W-1:0];
                    REG_COLS:     cols_in_use_reg <= cfg_wdata[SIZE_W-1:0];
                    default:      ;
                endcase
            end
            if (cmd.commit)
            begin
                win_up_reg     <= up_rd_reg;
                win_left_reg   <= win_center_reg;
                win_center_reg <= mid_rd_reg;
                win_down_reg   <= v_reg;
                if (emit_reg && last_reg)
                begin
                    row_cnt_reg <= '0;
                    col_cnt_reg <= '0;
                end
                else
                begin
                    row_cnt_reg <= row_cnt_next;
                    col_cnt_reg <= col_cnt_next;
                end
            end
        end
    end

    // line buffers, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            above_mem[col_cnt_reg]     <= v_reg;
            two_above_mem[col_cnt_reg] <= mid_rd_reg;
        end
        if (cmd.accept)
        begin
            up_rd_reg  <= two_above_mem[col_cnt_reg];
            mid_rd_reg <= above_mem[col_cnt_reg];
        end
    end

    // arithmetic stages
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            v_reg <= v_in;
        if (cmd.mul1)
        begin
            prod_x_reg   <= 37'(center_s) * 37'(diag_x_reg);
            prod_y_reg   <= 37'(center_s) * 37'(diag_y_reg);
            emit_reg     <= emit_now;
            interior_reg <= interior_now;
            last_reg     <= last_now;
        end
        if (cmd.sum)
        begin
            sx_reg <= $signed({4'b0, win_up_reg}) + $signed({4'b0, win_down_reg})
                      + prod_x_reg[36:16];
            sy_reg <= $signed({4'b0, win_left_reg}) + $signed({4'b0, mid_rd_reg})
                      + prod_y_reg[36:16];
        end
        if (cmd.mul2)
        begin
            tx_reg <= 40'(weight_x_reg) * 40'(sx_reg);
            ty_reg <= 40'(weight_y_reg) * 40'(sy_reg);
        end
        if (cmd.out_load)
        begin
            new_value_reg    <= result;
            last_of_grid_reg <= last_reg;
        end
    end

    assign status.emit  = emit_reg;
    assign new_value    = new_value_reg;
    assign last_of_grid = last_of_grid_reg;

endmodule

`default_nettype wire

/* design/hjs_ctrl.sv */
// Controller: sequences one cell through read, multiply, sum, multiply and
// commit, and owns the input ready and the output valid. Depends on hjs_pkg.
`default_nettype none

module hjs_ctrl
    import hjs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire hjs_status_t status,
    output hjs_cmd_t         cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // hold until the output register can take the result
                if (!status.emit || out_free)
                begin
                    cmd.commit   = 1'b1;
                    cmd.out_load = status.emit;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.mul1, cmd.sum, cmd.mul2, cmd.commit}))
        else $error("more than one datapath stage enabled");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (cmd.commit && out_free))
        else $error("result loaded over an untaken result");

    a_accept_then_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> cmd.mul1)
        else $error("read data not consumed after transfer");

    a_load_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

/* design/heat_jacobi_stencil_2d_unit.sv */
// Five-point Jacobi heat stencil, one cell per input transfer in raster order.
// Each cell runs read, multiply, sum, multiply and commit states; the next is taken after
// commit, which stalls on an untaken result and loads the result that the cell closes.
// Reset: async active low; config to defaults, window and counters cleared.
// Line buffers are not cleared; no clearing pass after reset.
`default_nettype none

module heat_jacobi_stencil_2d_unit
    import hjs_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    hjs_cell_if.sink                    cell_in,
    hjs_result_if.source                result_out,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [COEF_W-1:0]      cfg_wdata
);

    hjs_cmd_t    cmd;
    hjs_status_t status;

    hjs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cell_in.valid),
        .in_ready  (cell_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    hjs_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .cell_value   (cell_in.cell_value),
        .is_padding   (cell_in.is_padding),
        .cmd          (cmd),
        .status       (status),
        .new_value    (result_out.new_value),
        .last_of_grid (result_out.last_of_grid)
    );

endmodule

`default_nettype wire
